// ----- hdl/lock_table_manager_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef LOCK_TABLE_MANAGER_UNIT_DEFINES_SVH
`define LOCK_TABLE_MANAGER_UNIT_DEFINES_SVH

// implication in the same cycle, off while reset is low
`define LTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, off while reset is low
`define LTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// implication in the next cycle, also checked across reset
`define LTM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ltm_pkg.sv -----
package ltm_pkg;

  localparam int ACTION_W = 2;
  localparam int CLIENT_W = 8;
  localparam int LOCK_W   = 12;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STAT    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CLIENT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY         = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd4;

  localparam logic [CLIENT_W-1:0] NO_OWNER  = 8'hFF;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = 32'hFFFF_FFFF;

  // one table entry; held implies the lock has been seen
  typedef struct packed {
    logic                held;
    logic [CLIENT_W-1:0] owner;
    logic [COUNT_W-1:0]  count;
  } ltm_entry_t;

  localparam ltm_entry_t ENTRY_RESET = '{held: 1'b0, owner: NO_OWNER, count: '0};

  typedef struct packed {
    logic clear;   // write the reset entry at the clear index
    logic accept;  // take a request and start its table read
    logic commit;  // resolve the request, write back, load the result
  } ltm_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } ltm_sts_t;

endpackage

// ----- hdl/ltm_if.sv -----
interface ltm_req_if;
  logic                               valid;
  logic                               ready;
  logic [ltm_pkg::ACTION_W-1:0]       action;
  logic signed [ltm_pkg::CLIENT_W-1:0] client;
  logic [ltm_pkg::LOCK_W-1:0]         lock_id;

  modport source (output valid, action, client, lock_id, input ready);
  modport sink   (input valid, action, client, lock_id, output ready);
endinterface

interface ltm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ltm_pkg::STATUS_W-1:0] status;
  logic [ltm_pkg::COUNT_W-1:0]  count_value;

  modport source (output valid, status, count_value, input ready);
  modport sink   (input valid, status, count_value, output ready);
endinterface

// ----- hdl/ltm_datapath.sv -----
module ltm_datapath #(
  parameter int NUM_LOCKS = 64,
  parameter int IDX_W     = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ltm_pkg::ltm_cmd_t                   cmd,
  input  logic [IDX_W-1:0]                    clr_idx,
  output ltm_pkg::ltm_sts_t                   sts,
  input  logic [ltm_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [ltm_pkg::CLIENT_W-1:0] in_client,
  input  logic [ltm_pkg::LOCK_W-1:0]          in_lock_id,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ltm_pkg::STATUS_W-1:0]        out_status,
  output logic [ltm_pkg::COUNT_W-1:0]         out_count_value
);
  import ltm_pkg::*;

  ltm_entry_t            mem_r [NUM_LOCKS];
  ltm_entry_t            rd_data_r;
  logic [IDX_W-1:0]      rd_addr;
  logic [ACTION_W-1:0]   req_action_r;
  logic [CLIENT_W-1:0]   req_client_r;
  logic [IDX_W-1:0]      req_lock_r;
  logic                  req_oor_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic [STATUS_W-1:0]   res_status;
  logic [COUNT_W-1:0]    res_count;
  logic                  res_we;
  ltm_entry_t            res_entry;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  ltm_entry_t            mem_wd;

  assign rd_addr = cmd.accept ? in_lock_id[IDX_W-1:0] : req_lock_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_action_r <= in_action;
      req_client_r <= in_client;
      req_lock_r   <= in_lock_id[IDX_W-1:0];
      req_oor_r    <= ({1'b0, in_lock_id} >= (LOCK_W+1)'(NUM_LOCKS));
    end
  end

  // resolve the request against the entry read back
  always_comb begin
    res_status = ST_OK;
    res_count  = '0;
    res_we     = 1'b0;
    res_entry  = rd_data_r;
    if (req_oor_r) begin
      res_status = ST_OUT_OF_RANGE;
    end else begin
      case (req_action_r)
        ACT_ACQUIRE: begin
          if (req_client_r[CLIENT_W-1]) begin
            res_status = ST_BAD_CLIENT;
          end else if (rd_data_r.held) begin
            res_status = ST_BUSY;
          end else begin
            res_we          = 1'b1;
            res_entry.held  = 1'b1;
            res_entry.owner = req_client_r;
            if (rd_data_r.count != COUNT_MAX) begin
              res_entry.count = rd_data_r.count + COUNT_W'(1);
            end
          end
        end
        ACT_RELEASE: begin
          if (!rd_data_r.held) begin
            res_status = ST_NOT_FOUND;
          end else if (rd_data_r.owner != req_client_r) begin
            res_status = ST_BAD_CLIENT;
          end else begin
            res_we          = 1'b1;
            res_entry.held  = 1'b0;
            res_entry.owner = NO_OWNER;
          end
        end
        ACT_STAT: begin
          res_count = rd_data_r.count;
        end
        default: begin
          res_status = ST_OUT_OF_RANGE;
        end
      endcase
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = req_lock_r;
    mem_wd = res_entry;
    if (cmd.clear) begin
      mem_we = 1'b1;
      mem_wa = clr_idx;
      mem_wd = ENTRY_RESET;
    end else if (cmd.commit && res_we) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_count_r  <= res_count;
    end
  end

  assign sts.out_free     = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_count_value  = out_count_r;

endmodule

// ----- hdl/ltm_ctrl.sv -----
module ltm_ctrl #(
  parameter int NUM_LOCKS = 64,
  parameter int IDX_W     = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ltm_pkg::ltm_sts_t sts,
  output ltm_pkg::ltm_cmd_t cmd,
  output logic [IDX_W-1:0]  clr_idx
);
  import ltm_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             clr_last;

  assign clr_last = (clr_cnt_r == IDX_W'(NUM_LOCKS - 1));

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear   = 1'b1;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign clr_idx = clr_cnt_r;

endmodule

// ----- hdl/lock_table_manager_unit.sv -----
// channel   | dir | handshake          | payload
// in_req    | in  | valid / ready      | action, client, lock_id
// out_rsp   | out | valid / ready      | status, count_value
//
// each request is accepted with a table read, then resolved and written back
// one request is in flight at a time: the next is taken after the write back
// after reset a clearing pass resets all NUM_LOCKS entries with in_req.ready low
// the result sits in an output register; a stalled out_rsp holds the next
// request in its resolve cycle until the register frees
module lock_table_manager_unit #(
  parameter int NUM_LOCKS = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  ltm_req_if.sink   in_req,
  ltm_rsp_if.source out_rsp
);
  import ltm_pkg::*;

  // table index width, at least one bit for a single-lock table
  localparam int IDX_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

  ltm_cmd_t         cmd;
  ltm_sts_t         sts;
  logic [IDX_W-1:0] clr_idx;

  // sequencer: clearing pass, accept, resolve
  ltm_ctrl #(
    .NUM_LOCKS (NUM_LOCKS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd),
    .clr_idx  (clr_idx)
  );

  // lock table, request registers, decision logic and result register
  ltm_datapath #(
    .NUM_LOCKS (NUM_LOCKS),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .clr_idx         (clr_idx),
    .sts             (sts),
    .in_action       (in_req.action),
    .in_client       (in_req.client),
    .in_lock_id      (in_req.lock_id),
    .out_valid       (out_rsp.valid),
    .out_ready       (out_rsp.ready),
    .out_status      (out_rsp.status),
    .out_count_value (out_rsp.count_value)
  );

endmodule

// ----- hdl/ltm_checker.sv -----
`include "lock_table_manager_unit_defines.svh"

module ltm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ltm_pkg::STATUS_W-1:0] out_status,
  input logic [ltm_pkg::COUNT_W-1:0]  out_count_value
);
  import ltm_pkg::*;

  // a result that waits keeps its valid
  `LTM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // one request in flight: no accept in the cycle after an accept
  `LTM_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted back to back")

  // a failed request carries no count
  `LTM_ASSERT_NOW(a_count_zero, clk, rst_n, out_valid && out_status != ST_OK, out_count_value == '0, "count on a failed request")

  // reset puts the block into the clearing pass with the request side closed
  `LTM_ASSERT_NEXT_ALWAYS(a_clear_closed, clk, !rst_n, !in_ready, "request taken during table clear")

endmodule

bind lock_table_manager_unit ltm_checker u_ltm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_count_value (out_rsp.count_value)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import ltm_pkg::*;

  localparam int TABLE_SIZE      = 64;
  localparam int RANDOM_ITEMS    = 1400;
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the block up
  localparam int DRAIN_CYCLES    = 20;    // idle time after the last answer, leave plenty
  localparam int LOCK_ID_MAX     = (1 << LOCK_W) - 1;

  // action code the block does not define, answered as out of range
  localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;
  localparam logic [CLIENT_W-1:0] CLIENT_NONE = NO_OWNER;  // client -1

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count_value;
  } lock_rsp_t;

  // one row of the directed table; typed rows carry a hand-written answer
  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic signed [CLIENT_W-1:0] client;
    logic [LOCK_W-1:0]          lock_id;
    bit                         typed;
    lock_rsp_t                  rsp;
  } lock_row_t;

  logic clk;
  logic rst_n;

  ltm_req_if req_if ();
  ltm_rsp_if rsp_if ();

  lock_table_manager_unit #(
    .NUM_LOCKS (TABLE_SIZE)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if.sink),
    .out_rsp (rsp_if.source)
  );

  // shadow of the lock table, updated as each request transaction is accepted
  bit                  lock_seen   [TABLE_SIZE];
  bit                  lock_held   [TABLE_SIZE];
  logic [CLIENT_W-1:0] lock_holder [TABLE_SIZE];
  logic [COUNT_W-1:0]  lock_count  [TABLE_SIZE];

  lock_rsp_t pending_rsp[$];   // answers still owed by the block, oldest first
  lock_row_t directed_rows[$];

  int  fail_count     = 0;
  int  requests_sent  = 0;
  int  responses_seen = 0;
  int  status_tally [5];
  bit  idle_on        = 1'b0;  // random gaps on both sides when set
  bit  hold_off_req   = 1'b0;  // asks the receiver for one long stall

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // works out the answer to one request and moves the shadow table on
  function automatic lock_rsp_t resolve_request(input logic [ACTION_W-1:0] action,
                                                input logic [CLIENT_W-1:0] client,
                                                input logic [LOCK_W-1:0] lock_id);
    lock_rsp_t rsp;
    int        idx;
    rsp.status      = ST_OK;
    rsp.count_value = '0;
    idx             = int'(lock_id);
    // range check comes first, and the undefined action shares its code
    if (lock_id >= TABLE_SIZE || action == ACT_UNDEF) begin
      rsp.status = ST_OUT_OF_RANGE;
    end else if (action == ACT_ACQUIRE) begin
      if (client[CLIENT_W-1]) begin
        rsp.status = ST_BAD_CLIENT;
      end else if (lock_held[idx]) begin
        rsp.status = ST_BUSY;
      end else begin
        lock_seen[idx]   = 1'b1;
        lock_held[idx]   = 1'b1;
        lock_holder[idx] = client;
        // count saturates, the acquire still succeeds
        if (lock_count[idx] != COUNT_MAX) lock_count[idx] = lock_count[idx] + COUNT_W'(1);
      end
    end else if (action == ACT_RELEASE) begin
      if (!lock_seen[idx] || !lock_held[idx]) begin
        rsp.status = ST_NOT_FOUND;
      end else if (lock_holder[idx] != client) begin
        // client -1 never owns a lock, so it ends here whenever the lock is held
        rsp.status = ST_BAD_CLIENT;
      end else begin
        lock_held[idx]   = 1'b0;
        lock_holder[idx] = NO_OWNER;
      end
    end else begin
      rsp.count_value = lock_count[idx];
    end
    return rsp;
  endfunction

  function automatic lock_row_t make_row(input logic [ACTION_W-1:0] action,
                                         input int client, input int lock_id,
                                         input bit typed,
                                         input logic [STATUS_W-1:0] status);
    lock_row_t row;
    row.action          = action;
    row.client          = CLIENT_W'(client);
    row.lock_id         = LOCK_W'(lock_id);
    row.typed           = typed;
    row.rsp.status      = status;
    row.rsp.count_value = '0;
    return row;
  endfunction

  // offers one request, waits for its transaction, then maybe idles the input
  task automatic offer_request(input logic [ACTION_W-1:0] action,
                               input logic signed [CLIENT_W-1:0] client,
                               input logic [LOCK_W-1:0] lock_id,
                               input bit typed, input lock_rsp_t typed_rsp);
    lock_rsp_t predicted;
    int        gap;
    req_if.valid   <= 1'b1;
    req_if.action  <= action;
    req_if.client  <= client;
    req_if.lock_id <= lock_id;
    do @(posedge clk); while (!req_if.ready);
    predicted = resolve_request(action, client, lock_id);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    requests_sent++;
    gap = 0;
    if (idle_on) begin
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(10, 40);
        1, 2, 3: gap = $urandom_range(1, 3);
        4, 5:    gap = 1;
        default: gap = 0;
      endcase
    end
    // valid stays high into the next request when there is no gap
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver side: random stalls, runs of full rate, and one long hold-off
  initial begin : rsp_ready_drive
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // response checker: every accepted result against the oldest owed answer
  always @(posedge clk) begin : rsp_check
    lock_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding: status %0d count_value %0d",
               rsp_if.status, rsp_if.count_value);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.count_value !== want.count_value) begin
          $error("count_value expected %0d actual %0d", want.count_value, rsp_if.count_value);
          fail_count++;
        end
        if (rsp_if.status <= ST_OUT_OF_RANGE) status_tally[rsp_if.status]++;
        responses_seen++;
      end
    end
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [ACTION_W-1:0]        action;
    logic signed [CLIENT_W-1:0] client;
    logic [LOCK_W-1:0]          lock_id;
    lock_rsp_t                  no_rsp;
    int                         pick;

    no_rsp = '0;
    foreach (status_tally[i]) status_tally[i] = 0;
    // shadow table starts as the block does after reset
    for (int i = 0; i < TABLE_SIZE; i++) begin
      lock_seen[i]   = 1'b0;
      lock_held[i]   = 1'b0;
      lock_holder[i] = NO_OWNER;
      lock_count[i]  = '0;
    end

    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.action  <= ACT_ACQUIRE;
    req_if.client  <= '0;
    req_if.lock_id <= '0;

    // directed table: fresh table, range edges, every action, each error path
    directed_rows.push_back(make_row(ACT_STAT,    0,    0,            1, ST_OK));
    directed_rows.push_back(make_row(ACT_STAT,    -128, TABLE_SIZE-1, 1, ST_OK));
    directed_rows.push_back(make_row(ACT_RELEASE, 3,    5,            1, ST_NOT_FOUND));
    directed_rows.push_back(make_row(ACT_ACQUIRE, 1,    TABLE_SIZE,   1, ST_OUT_OF_RANGE));
    directed_rows.push_back(make_row(ACT_ACQUIRE, 127,  LOCK_ID_MAX,  1, ST_OUT_OF_RANGE));
    directed_rows.push_back(make_row(ACT_UNDEF,   0,    0,            1, ST_OUT_OF_RANGE));
    directed_rows.push_back(make_row(ACT_UNDEF,   -1,   LOCK_ID_MAX,  1, ST_OUT_OF_RANGE));
    directed_rows.push_back(make_row(ACT_STAT,    5,    LOCK_ID_MAX,  1, ST_OUT_OF_RANGE));
    directed_rows.push_back(make_row(ACT_RELEASE, 0,    TABLE_SIZE,   1, ST_OUT_OF_RANGE));
    directed_rows.push_back(make_row(ACT_ACQUIRE, -1,   0,            1, ST_BAD_CLIENT));
    directed_rows.push_back(make_row(ACT_ACQUIRE, -128, TABLE_SIZE-1, 1, ST_BAD_CLIENT));
    directed_rows.push_back(make_row(ACT_ACQUIRE, 0,    0,            1, ST_OK));
    directed_rows.push_back(make_row(ACT_ACQUIRE, 127,  0,            1, ST_BUSY));
    directed_rows.push_back(make_row(ACT_STAT,    9,    0,            0, ST_OK));
    directed_rows.push_back(make_row(ACT_RELEASE, 1,    0,            1, ST_BAD_CLIENT));
    directed_rows.push_back(make_row(ACT_RELEASE, -1,   0,            1, ST_BAD_CLIENT));
    directed_rows.push_back(make_row(ACT_RELEASE, 0,    0,            1, ST_OK));
    directed_rows.push_back(make_row(ACT_RELEASE, 0,    0,            1, ST_NOT_FOUND));
    directed_rows.push_back(make_row(ACT_ACQUIRE, 127,  TABLE_SIZE-1, 1, ST_OK));
    directed_rows.push_back(make_row(ACT_RELEASE, -128, TABLE_SIZE-1, 1, ST_BAD_CLIENT));
    directed_rows.push_back(make_row(ACT_ACQUIRE, 85,   0,            0, ST_OK));
    directed_rows.push_back(make_row(ACT_STAT,    -86,  0,            0, ST_OK));
    directed_rows.push_back(make_row(ACT_RELEASE, 127,  TABLE_SIZE-1, 0, ST_OK));
    directed_rows.push_back(make_row(ACT_STAT,    42,   TABLE_SIZE-1, 0, ST_OK));
    directed_rows.push_back(make_row(ACT_STAT,    -1,   1,            0, ST_OK));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at full rate; the clearing pass holds off the first one
    foreach (directed_rows[i])
      offer_request(directed_rows[i].action, directed_rows[i].client,
                    directed_rows[i].lock_id, directed_rows[i].typed,
                    directed_rows[i].typed ? directed_rows[i].rsp : no_rsp);

    // random part: mostly contended traffic on valid locks, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // every fourth block of 100 runs with no gaps on either side
      if (n % 100 == 0) idle_on = ((n / 100) % 4 != 1);

      // long receiver stall while the sender keeps offering back to back
      if (n == RANDOM_ITEMS / 3) begin
        hold_off_req = 1'b1;
        idle_on      = 1'b0;
      end
      // sender pause until the block has answered everything
      if (n == (2 * RANDOM_ITEMS) / 3) begin
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
      end

      pick = $urandom_range(0, 99);
      if (pick < 5)       action = ACT_UNDEF;
      else if (pick < 45) action = ACT_ACQUIRE;
      else if (pick < 82) action = ACT_RELEASE;
      else                action = ACT_STAT;

      pick = $urandom_range(0, 99);
      if (pick < 68)      lock_id = LOCK_W'($urandom_range(0, TABLE_SIZE - 1));
      else if (pick < 88) lock_id = LOCK_W'($urandom_range(0, 3));          // hot locks
      else if (pick < 94) lock_id = LOCK_W'($urandom_range(TABLE_SIZE, LOCK_ID_MAX));
      else                lock_id = LOCK_W'($urandom_range(0, LOCK_ID_MAX));

      // releases of held locks mostly come from the owner
      pick = $urandom_range(0, 99);
      if (action == ACT_RELEASE && lock_id < TABLE_SIZE && lock_held[lock_id] && pick < 60)
        client = lock_holder[lock_id];
      else if (pick < 70) client = CLIENT_W'($urandom_range(0, 15));
      else if (pick < 85) client = CLIENT_W'($urandom_range(0, 255));
      else if (pick < 92) client = CLIENT_NONE;
      else                client = CLIENT_W'($urandom_range(128, 255));

      offer_request(action, client, lock_id, 1'b0, no_rsp);
    end

    req_if.valid <= 1'b0;
    idle_on = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed) and %0d responses, with a long output stall",
             requests_sent, directed_rows.size(), responses_seen);
    $display("answers: ok %0d, not found %0d, bad client %0d, busy %0d, out of range %0d",
             status_tally[ST_OK], status_tally[ST_NOT_FOUND], status_tally[ST_BAD_CLIENT],
             status_tally[ST_BUSY], status_tally[ST_OUT_OF_RANGE]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
